### sv/stfr_pkg.sv
package stfr_pkg;

    // block sizing
    localparam int NUM_CHANNELS = 8;
    localparam int PACKET_BYTES = 14;
    localparam int STORE_DEPTH  = 32;

    // derived widths
    localparam int NUM_PAIRS = (NUM_CHANNELS + 1) / 2;
    localparam int CHAN_TOP  = 3 * NUM_PAIRS + 1;
    localparam int LAST_IDX  = (CHAN_TOP > PACKET_BYTES)
                             ? ((CHAN_TOP > STORE_DEPTH) ? CHAN_TOP : STORE_DEPTH)
                             : ((PACKET_BYTES > STORE_DEPTH) ? PACKET_BYTES : STORE_DEPTH);
    localparam int IDX_W   = $clog2(LAST_IDX + 1);
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int FILL_W  = $clog2(STORE_DEPTH + 1);
    localparam int CH_W    = $clog2(NUM_CHANNELS);
    localparam int PADDR_W = 4;

    // channel decode
    localparam logic [12:0] CHAN_OFFSET = 13'd1500;

    // register map (word index) and reset values
    localparam logic [1:0] REG_DELIM  = 2'd0;
    localparam logic [1:0] REG_ESCAPE = 2'd1;
    localparam logic [1:0] REG_MASK   = 2'd2;
    localparam logic [1:0] REG_FTYPE  = 2'd3;

    localparam logic [7:0] RST_DELIM  = 8'd126;
    localparam logic [7:0] RST_ESCAPE = 8'd125;
    localparam logic [7:0] RST_MASK   = 8'd32;
    localparam logic [7:0] RST_FTYPE  = 8'd128;

    // byte receiver states
    typedef enum logic [1:0] {
        P_IDLE     = 2'd0,
        P_START    = 2'd1,
        P_IN_FRAME = 2'd2,
        P_ESCAPE   = 2'd3
    } t_parse;

    // sequencer states
    typedef enum logic [2:0] {
        S_WAIT,
        S_TEST,
        S_CHECK,
        S_DECIDE,
        S_LOAD,
        S_EVEN,
        S_ODD
    } t_ctrl_state;

    typedef struct packed {
        logic [7:0] delim;
        logic [7:0] escape;
        logic [7:0] mask;
        logic [7:0] ftype;
    } t_cfg;

    typedef struct packed {
        logic             step;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             chk_first;
        logic             chk_acc;
        logic             chk_last;
        logic             ld_b0;
        logic             ld_b1;
        logic             ld_b2;
        logic             odd;
    } t_cmd;

    typedef struct packed {
        logic need_check;
        logic frame_ok;
    } t_stat;

endpackage

### sv/stfr_dp.sv
module stfr_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stfr_pkg::t_cfg       i_cfg,
    input  stfr_pkg::t_cmd       i_cmd,
    input  logic [7:0]           i_rx_byte,
    output stfr_pkg::t_stat      o_stat,
    output logic signed [12:0]   o_channel_value
);
    import stfr_pkg::*;

    t_parse            r_parse, n_parse;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [7:0]        mem [STORE_DEPTH];
    logic              wr_req, wr_en;
    logic [7:0]        wr_data;
    logic [7:0]        r_rd_data;
    logic              r_rd_zero;
    logic [7:0]        rd_byte;
    logic [7:0]        r_xor;
    logic              r_type_ok;
    logic              r_ok;
    logic [7:0]        r_b0, r_b1, r_b2;
    logic [11:0]       raw;

    // byte receiver: next state, fill count and store write
    always_comb begin
        n_parse = r_parse;
        n_fill  = r_fill;
        wr_req  = 1'b0;
        wr_en   = 1'b0;
        wr_data = i_rx_byte;
        if (i_cmd.step) begin
            case (r_parse)
                P_START: begin
                    if (i_rx_byte == i_cfg.delim) begin
                        n_parse = P_IN_FRAME;
                        n_fill  = '0;
                    end else begin
                        wr_req = 1'b1;
                    end
                end
                P_IN_FRAME: begin
                    if (i_rx_byte == i_cfg.escape) begin
                        n_parse = P_ESCAPE;
                    end else if (i_rx_byte == i_cfg.delim) begin
                        n_fill = '0;
                    end else begin
                        wr_req = 1'b1;
                    end
                end
                P_ESCAPE: begin
                    if (i_rx_byte == (i_cfg.escape ^ i_cfg.mask) ||
                        i_rx_byte == (i_cfg.delim ^ i_cfg.mask)) begin
                        wr_req  = 1'b1;
                        wr_data = i_rx_byte ^ i_cfg.mask;
                        n_parse = P_IN_FRAME;
                    end else if (i_rx_byte == i_cfg.delim) begin
                        n_fill  = '0;
                        n_parse = P_IN_FRAME;
                    end else begin
                        n_parse = P_START;
                    end
                end
                default: begin
                    if (i_rx_byte == i_cfg.delim) begin
                        n_fill  = '0;
                        n_parse = P_START;
                    end else begin
                        wr_req = 1'b1;
                    end
                end
            endcase
            if (wr_req && (r_fill < FILL_W'(STORE_DEPTH))) begin
                wr_en  = 1'b1;
                n_fill = r_fill + 1'b1;
            end
            // a complete packet sends the receiver back to idle
            if (32'(n_fill) >= 32'(PACKET_BYTES)) begin
                n_parse = P_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse <= P_IDLE;
            r_fill  <= '0;
        end else begin
            r_parse <= n_parse;
            r_fill  <= n_fill;
        end
    end

    // frame store write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_fill[ADDR_W-1:0]] <= wr_data;
        end
    end

    // frame store read port, indexes past the store read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_cmd.rd_addr[ADDR_W-1:0]];
            r_rd_zero <= (i_cmd.rd_addr >= IDX_W'(STORE_DEPTH));
        end
    end

    assign rd_byte = r_rd_zero ? 8'h00 : r_rd_data;

    // xor walk and frame type check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= 1'b0;
        end else if (i_cmd.chk_last) begin
            r_ok <= r_type_ok && (r_xor == rd_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.chk_first) begin
            r_xor     <= rd_byte;
            r_type_ok <= (rd_byte == i_cfg.ftype);
        end else if (i_cmd.chk_acc) begin
            r_xor <= r_xor ^ rd_byte;
        end
    end

    // channel pair bytes
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_b0) r_b0 <= rd_byte;
        if (i_cmd.ld_b1) r_b1 <= rd_byte;
        if (i_cmd.ld_b2) r_b2 <= rd_byte;
    end

    // channel unpack and offset
    assign raw = i_cmd.odd ? {r_b2[3:0], r_b1[3:0], r_b2[7:4]}
                           : {r_b1[7:4], r_b0};
    assign o_channel_value = signed'({1'b0, raw} - CHAN_OFFSET);

    assign o_stat.need_check = (32'(r_fill) >= 32'(PACKET_BYTES));
    assign o_stat.frame_ok   = r_ok;

    // fill count never passes the store depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(STORE_DEPTH))
        else $error("fill count beyond store depth");

    // a full packet always leaves the receiver idle
    a_full_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_fill) >= 32'(PACKET_BYTES)) |-> (r_parse == P_IDLE))
        else $error("receiver not idle with full packet");

endmodule

### sv/stfr_ctrl.sv
module stfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  stfr_pkg::t_stat   i_stat,
    output stfr_pkg::t_cmd    o_cmd,
    output logic [2:0]        o_channel_index,
    output logic              o_last_channel
);
    import stfr_pkg::*;

    t_ctrl_state      r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0]       r_sub, n_sub;
    logic [CH_W-1:0]  r_ch, n_ch;
    logic             last_ch;

    assign last_ch = (r_ch == CH_W'(NUM_CHANNELS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
            r_idx   <= '0;
            r_sub   <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_sub   <= n_sub;
            r_ch    <= n_ch;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_sub   = r_sub;
        n_ch    = r_ch;
        o_cmd   = '0;
        o_cmd.rd_addr = r_idx;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_WAIT: begin
                o_ready    = 1'b1;
                o_cmd.step = i_valid;
                if (i_valid) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                n_idx = '0;
                if (i_stat.need_check) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_CHECK: begin
                // read byte r_idx, work on byte r_idx-1
                o_cmd.rd_en     = (r_idx < IDX_W'(PACKET_BYTES));
                o_cmd.chk_first = (r_idx == IDX_W'(1));
                o_cmd.chk_acc   = (r_idx > IDX_W'(1)) && (r_idx < IDX_W'(PACKET_BYTES));
                o_cmd.chk_last  = (r_idx == IDX_W'(PACKET_BYTES));
                n_idx = r_idx + 1'b1;
                if (r_idx == IDX_W'(PACKET_BYTES)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_idx = IDX_W'(1);
                n_sub = '0;
                n_ch  = '0;
                if (i_stat.frame_ok) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_LOAD: begin
                // three reads of one channel pair, each captured in the cycle after its read
                o_cmd.rd_en = (r_sub != 2'd3);
                o_cmd.ld_b0 = (r_sub == 2'd1);
                o_cmd.ld_b1 = (r_sub == 2'd2);
                o_cmd.ld_b2 = (r_sub == 2'd3);
                n_sub = r_sub + 1'b1;
                if (r_sub != 2'd3) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = S_EVEN;
                end
            end
            S_EVEN: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (last_ch) begin
                        n_state = S_WAIT;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = S_ODD;
                    end
                end
            end
            S_ODD: begin
                o_valid   = 1'b1;
                o_cmd.odd = 1'b1;
                if (i_ready) begin
                    if (last_ch) begin
                        n_state = S_WAIT;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_sub   = '0;
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase
    end

    assign o_channel_index = 3'(r_ch);
    assign o_last_channel  = last_ch;

    // never take a byte while a channel word is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output both open");

    // the last channel word hands control back to the byte receiver
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_channel) |=> o_ready)
        else $error("not ready after last channel");

    // every emitted word follows a passed check
    a_emit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> i_stat.frame_ok)
        else $error("channel word without passed check");

endmodule

### sv/stuffed_trainer_frame_receiver.sv
// Trainer frame receiver: takes raw link bytes, strips delimiter and escape
// stuffing, and stores frame bytes; once the fill count reaches the packet
// size it walks the store to check the xor sum and the frame type byte, and
// on a good frame sends the channel words in channel order, each decoded
// 12-bit value minus 1500. A byte that completes no packet goes through the
// wait and test states. A byte that completes one also starts the check walk
// through the single store read port, and a good frame then adds the store
// reads of each channel pair and one output word per channel, longer if the
// output stalls. Bytes are taken again after the last word.
// The fill count is not cleared by a check, so further non-delimiter bytes
// in idle check and resend the same frame. Registers: delimiter at 0x0,
// escape at 0x4, stuff mask at 0x8, frame type at 0xc, low 8 bits used.
module stuffed_trainer_frame_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [stfr_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [2:0]                     o_channel_index,
    output logic signed [12:0]             o_channel_value,
    output logic                           o_last_channel
);
    import stfr_pkg::*;

    t_cfg       r_cfg;
    t_cmd       cmd;
    t_stat      stat;
    logic       wr_go;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_go   = psel && penable && pwrite;
    assign reg_sel = paddr[PADDR_W-1:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delim  <= RST_DELIM;
            r_cfg.escape <= RST_ESCAPE;
            r_cfg.mask   <= RST_MASK;
            r_cfg.ftype  <= RST_FTYPE;
        end else if (wr_go) begin
            case (reg_sel)
                REG_DELIM:  r_cfg.delim  <= pwdata[7:0];
                REG_ESCAPE: r_cfg.escape <= pwdata[7:0];
                REG_MASK:   r_cfg.mask   <= pwdata[7:0];
                REG_FTYPE:  r_cfg.ftype  <= pwdata[7:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            REG_DELIM:  prdata = 32'(r_cfg.delim);
            REG_ESCAPE: prdata = 32'(r_cfg.escape);
            REG_MASK:   prdata = 32'(r_cfg.mask);
            REG_FTYPE:  prdata = 32'(r_cfg.ftype);
            default:    prdata = '0;
        endcase
    end

    stfr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .i_stat          (stat),
        .o_cmd           (cmd),
        .o_channel_index (o_channel_index),
        .o_last_channel  (o_last_channel)
    );

    stfr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (cmd),
        .i_rx_byte       (i_rx_byte),
        .o_stat          (stat),
        .o_channel_value (o_channel_value)
    );

endmodule
